@@ hdl/i2cmbe_pkg.sv @@
// shared types, constants and helpers of the i2c master byte engine
package i2cmbe_pkg;

    localparam int DELAY_BITS = 16;

    localparam logic [15:0] DELAY_TICKS_RESET = 16'd10;

    localparam logic [7:0] ADDR_READ_SET   = 8'h01;
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] MSB_MASK        = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ADDR_NONE  = 2'd0,
        ADDR_READ  = 2'd1,
        ADDR_WRITE = 2'd2,
        ADDR_KEEP  = 2'd3
    } addr_mode_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST1  = 5'd1,
        PH_ST2  = 5'd2,
        PH_SP1  = 5'd3,
        PH_SP2  = 5'd4,
        PH_SP3  = 5'd5,
        PH_TX1  = 5'd6,
        PH_TX2  = 5'd7,
        PH_TX3  = 5'd8,
        PH_TX4  = 5'd9,
        PH_TX5  = 5'd10,
        PH_RX1  = 5'd11,
        PH_RX2  = 5'd12,
        PH_RX3  = 5'd13
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic [1:0] addr_mode;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       acked;
    } result_t;

    // bus delay load value, saturated to the counter width
    function automatic logic [DELAY_BITS-1:0] load_delay(input logic [15:0] ticks);
        logic [63:0] max_val;
        logic [63:0] d;
        max_val = (64'd1 << DELAY_BITS) - 64'd1;
        d       = 64'(ticks);
        return (d > max_val) ? max_val[DELAY_BITS-1:0] : d[DELAY_BITS-1:0];
    endfunction

endpackage

@@ hdl/i2cmbe_seq.sv @@
// bus sequencer: phase machine, bit shifter and delay counter
module i2cmbe_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  i2cmbe_pkg::item_t    item,
    input  logic [15:0]          delay_ticks,
    output i2cmbe_pkg::result_t  res
);

    i2cmbe_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic [i2cmbe_pkg::DELAY_BITS-1:0] delay_count_reg, delay_count_next;
    logic [7:0]  last_rx_reg, last_rx_next;
    logic        last_ack_reg, last_ack_next;
    logic        ack_to_send_reg, ack_to_send_next;
    logic        scl_out_reg, scl_out_next;
    logic        sda_out_reg, sda_out_next;
    logic        run;
    logic        done;
    logic [7:0]  tx_data;
    logic [3:0]  bit_inc;
    logic [7:0]  tx_shifted;

    assign run        = (delay_count_reg == '0);
    assign bit_inc    = bit_count_reg + 4'd1;
    assign tx_shifted = {shift_reg[6:0], 1'b0};

    always_comb
    begin
        case (i2cmbe_pkg::addr_mode_t'(item.addr_mode))
            i2cmbe_pkg::ADDR_READ:  tx_data = item.tx_byte | i2cmbe_pkg::ADDR_READ_SET;
            i2cmbe_pkg::ADDR_WRITE: tx_data = item.tx_byte & i2cmbe_pkg::ADDR_WRITE_MASK;
            default:                tx_data = item.tx_byte;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == i2cmbe_pkg::PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                case (i2cmbe_pkg::op_t'(item.op))
                    i2cmbe_pkg::OP_START: phase_next = i2cmbe_pkg::PH_ST1;
                    i2cmbe_pkg::OP_STOP:  phase_next = i2cmbe_pkg::PH_SP1;
                    i2cmbe_pkg::OP_WRITE: phase_next = i2cmbe_pkg::PH_TX1;
                    default:              phase_next = i2cmbe_pkg::PH_RX1;
                endcase
            end
        end
        else if (run)
        begin
            case (phase_reg)
                i2cmbe_pkg::PH_ST1: phase_next = i2cmbe_pkg::PH_ST2;
                i2cmbe_pkg::PH_ST2: phase_next = i2cmbe_pkg::PH_IDLE;
                i2cmbe_pkg::PH_SP1: phase_next = i2cmbe_pkg::PH_SP2;
                i2cmbe_pkg::PH_SP2: phase_next = i2cmbe_pkg::PH_SP3;
                i2cmbe_pkg::PH_SP3: phase_next = i2cmbe_pkg::PH_IDLE;
                i2cmbe_pkg::PH_TX1: phase_next = i2cmbe_pkg::PH_TX2;
                i2cmbe_pkg::PH_TX2:
                    phase_next = (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) ?
                                 i2cmbe_pkg::PH_TX1 : i2cmbe_pkg::PH_TX3;
                i2cmbe_pkg::PH_TX3: phase_next = i2cmbe_pkg::PH_TX4;
                i2cmbe_pkg::PH_TX4: phase_next = i2cmbe_pkg::PH_TX5;
                i2cmbe_pkg::PH_TX5:
                    phase_next = item.scl_in ? i2cmbe_pkg::PH_IDLE : i2cmbe_pkg::PH_TX5;
                i2cmbe_pkg::PH_RX1:
                    phase_next = item.scl_in ? i2cmbe_pkg::PH_RX2 : i2cmbe_pkg::PH_RX1;
                i2cmbe_pkg::PH_RX2:
                    phase_next = (bit_inc < i2cmbe_pkg::BITS_PER_BYTE) ?
                                 i2cmbe_pkg::PH_RX1 : i2cmbe_pkg::PH_RX3;
                i2cmbe_pkg::PH_RX3: phase_next = i2cmbe_pkg::PH_IDLE;
                default:            phase_next = i2cmbe_pkg::PH_IDLE;
            endcase
        end
    end

    // line, shifter and counter updates
    always_comb
    begin
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        last_rx_next     = last_rx_reg;
        last_ack_next    = last_ack_reg;
        ack_to_send_next = ack_to_send_reg;
        scl_out_next     = scl_out_reg;
        sda_out_next     = sda_out_reg;
        if (phase_reg == i2cmbe_pkg::PH_IDLE)
        begin
            if (item.cmd_valid)
            begin
                delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                case (i2cmbe_pkg::op_t'(item.op))
                    i2cmbe_pkg::OP_START:
                    begin
                        sda_out_next = 1'b1;
                        scl_out_next = 1'b1;
                    end
                    i2cmbe_pkg::OP_STOP:
                        sda_out_next = 1'b0;
                    i2cmbe_pkg::OP_WRITE:
                    begin
                        shift_next     = tx_data;
                        bit_count_next = '0;
                        sda_out_next   = |(tx_data & i2cmbe_pkg::MSB_MASK);
                    end
                    default:
                    begin
                        ack_to_send_next = item.send_ack;
                        shift_next       = '0;
                        bit_count_next   = '0;
                        sda_out_next     = 1'b1;
                        scl_out_next     = 1'b1;
                    end
                endcase
            end
        end
        else if (!run)
        begin
            delay_count_next = delay_count_reg - i2cmbe_pkg::DELAY_BITS'(1);
        end
        else
        begin
            case (phase_reg)
                i2cmbe_pkg::PH_ST1:
                begin
                    sda_out_next     = 1'b0;
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_ST2:
                    scl_out_next = 1'b0;
                i2cmbe_pkg::PH_SP1:
                begin
                    scl_out_next     = 1'b1;
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_SP2:
                begin
                    sda_out_next     = 1'b1;
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_TX1:
                begin
                    scl_out_next     = 1'b1;
                    shift_next       = tx_shifted;
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_TX2:
                begin
                    scl_out_next     = 1'b0;
                    bit_count_next   = bit_inc;
                    if (bit_inc < i2cmbe_pkg::BITS_PER_BYTE)
                    begin
                        sda_out_next = |(shift_reg & i2cmbe_pkg::MSB_MASK);
                    end
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_TX3:
                begin
                    sda_out_next     = 1'b1;
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_TX4:
                    scl_out_next = 1'b1;
                i2cmbe_pkg::PH_TX5:
                begin
                    if (item.scl_in)
                    begin
                        last_ack_next = !item.sda_in;
                        scl_out_next  = 1'b0;
                        sda_out_next  = 1'b1;
                    end
                end
                i2cmbe_pkg::PH_RX1:
                begin
                    if (item.scl_in)
                    begin
                        shift_next       = {shift_reg[6:0], item.sda_in};
                        scl_out_next     = 1'b0;
                        delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                    end
                end
                i2cmbe_pkg::PH_RX2:
                begin
                    bit_count_next = bit_inc;
                    scl_out_next   = 1'b1;
                    if (!(bit_inc < i2cmbe_pkg::BITS_PER_BYTE))
                    begin
                        sda_out_next = !ack_to_send_reg;
                    end
                    delay_count_next = i2cmbe_pkg::load_delay(delay_ticks);
                end
                i2cmbe_pkg::PH_RX3:
                begin
                    scl_out_next = 1'b0;
                    sda_out_next = 1'b0;
                    last_rx_next = shift_reg;
                end
                default:
                begin
                    scl_out_next = scl_out_reg;
                end
            endcase
        end
    end

    // per-word outputs
    always_comb
    begin
        done = 1'b0;
        if (phase_reg != i2cmbe_pkg::PH_IDLE && run)
        begin
            case (phase_reg)
                i2cmbe_pkg::PH_ST2: done = 1'b1;
                i2cmbe_pkg::PH_SP3: done = 1'b1;
                i2cmbe_pkg::PH_RX3: done = 1'b1;
                i2cmbe_pkg::PH_TX5: done = item.scl_in;
                default:            done = 1'b0;
            endcase
        end
        res.scl_release = scl_out_next;
        res.sda_release = sda_out_next;
        res.busy        = (phase_next != i2cmbe_pkg::PH_IDLE);
        res.done        = done;
        res.rx_byte     = last_rx_next;
        res.acked       = last_ack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= i2cmbe_pkg::PH_IDLE;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            delay_count_reg <= '0;
            last_rx_reg     <= '0;
            last_ack_reg    <= 1'b0;
            ack_to_send_reg <= 1'b0;
            scl_out_reg     <= 1'b1;
            sda_out_reg     <= 1'b1;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            delay_count_reg <= delay_count_next;
            last_rx_reg     <= last_rx_next;
            last_ack_reg    <= last_ack_next;
            ack_to_send_reg <= ack_to_send_next;
            scl_out_reg     <= scl_out_next;
            sda_out_reg     <= sda_out_next;
        end
    end

    // a running delay holds the phase
    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg != i2cmbe_pkg::PH_IDLE && !run |=> $stable(phase_reg))
        else $error("phase moved during bus delay");

    // bit counter never passes one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= i2cmbe_pkg::BITS_PER_BYTE)
        else $error("bit counter overran");

    // completion only leaves a running sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == i2cmbe_pkg::PH_IDLE)
        else $error("done without return to idle");

endmodule

@@ hdl/i2c_master_byte_engine.sv @@
// top level of the i2c master byte engine: handshake, delay register, result register
//
// Each input word is one tick of the bus sequencer and yields exactly one result word
// carrying the SCL and SDA release levels, busy, done, the last received byte and the
// last write ack, all as they stand after that tick. A new word is taken every cycle
// unless the output is stalled; the sequencer updates its state in the accepting cycle
// and the result lands in an output register, refilled in the same cycle it is taken.
// Throughput is one word per clock unless the output register stalls and holds off input.
// Commands (start, stop, write byte, read byte) are taken only while idle and ignored
// otherwise. Every bus step but the ack sample waits delay_ticks + 1 ticks; waits for SCL
// high have no limit, so a slave may stretch the clock. delay_ticks resets to 10 and the
// user writes it through cfg_we / cfg_data only while the engine is idle (unchecked).
module i2c_master_byte_engine (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd_valid,
    input  logic [1:0]  op,
    input  logic [7:0]  tx_byte,
    input  logic [1:0]  addr_mode,
    input  logic        send_ack,
    input  logic        scl_in,
    input  logic        sda_in,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_release,
    output logic        sda_release,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        acked
);

    logic [15:0]          delay_ticks_reg;
    logic                 out_valid_reg, out_valid_next;
    i2cmbe_pkg::result_t  res_reg;
    i2cmbe_pkg::result_t  res_step;
    i2cmbe_pkg::item_t    item;
    logic                 accept;

    // room when the result register is empty or being drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign item.cmd_valid = cmd_valid;
    assign item.op        = op;
    assign item.tx_byte   = tx_byte;
    assign item.addr_mode = addr_mode;
    assign item.send_ack  = send_ack;
    assign item.scl_in    = scl_in;
    assign item.sda_in    = sda_in;

    i2cmbe_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .item        (item),
        .delay_ticks (delay_ticks_reg),
        .res         (res_step)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // delay register and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= i2cmbe_pkg::DELAY_TICKS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_ticks_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_step;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = res_reg.scl_release;
    assign sda_release = res_reg.sda_release;
    assign busy_res    = res_reg.busy;
    assign done_res    = res_reg.done;
    assign rx_byte     = res_reg.rx_byte;
    assign acked       = res_reg.acked;

    // a completion word never reports busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.done && res_reg.busy))
        else $error("done and busy in one word");

    // an empty result register always takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output");

    // an accepted word always shows up next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word lost");

endmodule
